@@ rtl/wfr_pkg.sv @@
// Shared types and constants of the water frame receiver.
package wfr_pkg;

  localparam int unsigned FrameLen = 8;

  // input op codes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } wfr_op_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_TICK  = 2'd2
  } wfr_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT     = 2'd0,
    CFG_MARKER_LOW  = 2'd1,
    CFG_MARKER_HIGH = 2'd2
  } wfr_cfg_e;

  localparam logic [7:0]  TimeoutReset    = 8'd150;
  localparam logic [7:0]  MarkerLowReset  = 8'hDE;
  localparam logic [7:0]  MarkerHighReset = 8'hC0;
  localparam logic [31:0] UvMin           = 32'd500000;
  localparam logic [31:0] UvMax           = 32'd2500000;
  localparam logic [9:0]  CmMin           = 10'd50;
  localparam logic [10:0] CmMax           = 11'd1000;
  localparam logic [9:0]  CmSpan          = 10'd950;
  localparam logic [7:0]  IdleMax         = 8'hFF;

  // uV span is 2^7 * 15625; floor(x / 15625) = (x * RecipM) >> RecipShift for x < 2^24
  localparam int unsigned SpanShift  = 7;
  localparam logic [24:0] RecipM     = 25'd17592187;
  localparam int unsigned RecipShift = 38;

  // offset above UvMin, below 2^21
  localparam int unsigned OffW  = 21;
  // offset times CmSpan, below 2^31
  localparam int unsigned ProdW = 31;

  // load enables of the level conversion stages
  typedef struct packed {
    logic s3;
    logic s4;
  } wfr_adv_t;

endpackage

@@ rtl/wfr_cell.sv @@
// One byte cell of the sliding window, with its slice of the checksum chain.
module wfr_cell import wfr_pkg::*; (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] sum_i,
  output logic [7:0] byte_o,
  output logic [7:0] sum_o
);

  logic [7:0] byte_q, byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;
  // checksum is modulo 256
  assign sum_o  = sum_i + byte_q;

endmodule

@@ rtl/wfr_level.sv @@
// Two-stage conversion of the microvolt offset into a level in cm.
module wfr_level import wfr_pkg::*; (
  input  logic            clk_i,
  input  wfr_adv_t        adv_i,
  input  logic            frame_i,
  input  logic [OffW-1:0] off_i,
  output logic [9:0]      level_o
);

  logic [ProdW-1:0] prod_q, prod_d;
  logic             frame_q;
  logic [9:0]       level_q, level_d;

  logic [23:0] scaled;
  logic [48:0] recip;
  logic [10:0] quot;
  logic [10:0] cm;

  assign prod_d = ProdW'(off_i * CmSpan);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      prod_q  <= prod_d;
      frame_q <= frame_i;
    end
  end

  // divide by the uV span: shift by 2^7, then reciprocal multiply for 15625
  assign scaled = prod_q[ProdW-1:SpanShift];
  assign recip  = 49'(scaled) * 49'(RecipM);
  assign quot   = recip[48:RecipShift];
  assign cm     = 11'(CmMin) + quot;

  always_comb begin
    level_d = '0;
    if (frame_q) begin
      level_d = (cm > CmMax) ? 10'(CmMax) : cm[9:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

@@ rtl/water_frame_receiver.sv @@
// Top level of the water frame receiver: window cells, frame check, tracking and output pipe.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: data_byte; tuser: op, operational
//  m_axis    | out | m_axis_tvalid/tready    | tdata: level_cm, frame_counter, break, defect
//            |     |                         | tuser: kind
//  cfg       | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// One request per clock sustained while m_axis_tready holds; each request gives exactly one
// result, valid on m_axis after four register stages, the first loaded at acceptance.
// Stage 1 is the row of eight byte cells (the window) plus the request flags. The frame
// check and all tracking state update on the move from stage 1 to stage 2, so requests
// update state strictly in order. Stages 3 and 4 scale the voltage to cm (one multiply each).
// Every stage has its own valid bit and moves when the next one is free or moving, so a
// stalled output only blocks input once all four stages are full.
// Reset clears valids, fill count, tracking state and loads register defaults; window
// bytes are not reset and are only checked after eight bytes have entered.
module water_frame_receiver import wfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [0] op, [1] operational

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] level_cm, [17:10] frame_counter,
                                      // [18] counter_break, [19] water_defect, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // ---------------- configuration registers ----------------
  logic [7:0] timeout_q, marker_lo_q, marker_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      marker_lo_q <= MarkerLowReset;
      marker_hi_q <= MarkerHighReset;
    end else if (cfg_valid_i) begin
      // index beyond the list is dropped
      unique case (wfr_cfg_e'(cfg_index_i))
        CFG_TIMEOUT:     timeout_q   <= cfg_data_i;
        CFG_MARKER_LOW:  marker_lo_q <= cfg_data_i;
        CFG_MARKER_HIGH: marker_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic acc1, adv2, adv3, adv4;
  wfr_adv_t lvl_adv;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign acc1 = s_axis_tvalid && rdy1;
  assign adv2 = v1_q && rdy2;
  assign adv3 = v2_q && rdy3;
  assign adv4 = v3_q && rdy4;

  assign lvl_adv.s3 = adv3;
  assign lvl_adv.s4 = adv4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: request flags, window cells, fill count ----------------
  logic op1_q, oper1_q;
  logic push;
  logic [3:0] fill_q, fill_d;
  logic [7:0] win [FrameLen];
  logic [7:0] sum_c [FrameLen+1];

  assign push = acc1 && s_axis_tuser[1] && (wfr_op_e'(s_axis_tuser[0]) == OP_BYTE);

  always_ff @(posedge clk_i) begin
    if (acc1) begin
      op1_q   <= s_axis_tuser[0];
      oper1_q <= s_axis_tuser[1];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (acc1 && !s_axis_tuser[1]) begin
      fill_d = '0;
    end else if (push && (fill_q < 4'(FrameLen))) begin
      fill_d = fill_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // newest byte enters the top cell, oldest sits in cell 0
  assign sum_c[0] = '0;

  for (genvar k = 0; k < FrameLen; k++) begin : g_cell
    logic [7:0] nxt;
    if (k == FrameLen - 1) begin : g_top
      assign nxt = s_axis_tdata;
    end else begin : g_mid
      assign nxt = win[k+1];
    end
    wfr_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(push),
      .byte_i (nxt),
      .sum_i  (sum_c[k]),
      .byte_o (win[k]),
      .sum_o  (sum_c[k+1])
    );
  end

  // ---------------- frame check (stage 1 -> 2) ----------------
  logic [31:0] uv;
  logic        frame_ok;

  assign uv = {win[4], win[3], win[2], win[1]};

  // checksum byte makes the sum of all eight bytes zero mod 256
  assign frame_ok = (fill_q >= 4'(FrameLen)) &&
                    (win[5] == marker_lo_q) && (win[6] == marker_hi_q) &&
                    (sum_c[FrameLen] == 8'd0) &&
                    (uv >= UvMin) && (uv <= UvMax);

  // ---------------- tracking state ----------------
  logic [7:0] last_cnt_q, last_cnt_d;
  logic       have_q, have_d;
  logic [7:0] idle_q, idle_d;
  logic       fcyc_q, fcyc_d;
  logic       bcyc_q, bcyc_d;

  wfr_kind_e       kind2_d;
  logic [7:0]      cnt2_d;
  logic            brk2_d, def2_d;
  logic [OffW-1:0] off2_d;

  always_comb begin
    logic [7:0] idle_inc;
    logic       brk;

    last_cnt_d = last_cnt_q;
    have_d     = have_q;
    idle_d     = idle_q;
    fcyc_d     = fcyc_q;
    bcyc_d     = bcyc_q;
    kind2_d    = KIND_BYTE;
    cnt2_d     = '0;
    brk2_d     = 1'b0;
    def2_d     = 1'b0;
    off2_d     = '0;
    idle_inc   = idle_q;
    brk        = 1'b0;

    if (!oper1_q) begin
      // reception off: drop tracking, keep last counter value
      idle_d  = '0;
      have_d  = 1'b0;
      fcyc_d  = 1'b0;
      bcyc_d  = 1'b0;
      kind2_d = (wfr_op_e'(op1_q) == OP_TICK) ? KIND_TICK : KIND_BYTE;
    end else if (wfr_op_e'(op1_q) == OP_TICK) begin
      if (!fcyc_q && (idle_q < IdleMax)) begin
        idle_inc = idle_q + 8'd1;
      end
      idle_d  = idle_inc;
      def2_d  = bcyc_q || (idle_inc >= timeout_q);
      fcyc_d  = 1'b0;
      bcyc_d  = 1'b0;
      kind2_d = KIND_TICK;
    end else if (frame_ok) begin
      brk        = have_q && (win[0] != (last_cnt_q + 8'd1));
      bcyc_d     = bcyc_q || brk;
      last_cnt_d = win[0];
      have_d     = 1'b1;
      idle_d     = '0;
      fcyc_d     = 1'b1;
      kind2_d    = KIND_FRAME;
      cnt2_d     = win[0];
      brk2_d     = brk;
      off2_d     = OffW'(uv - UvMin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
      have_q     <= 1'b0;
      idle_q     <= '0;
      fcyc_q     <= 1'b0;
      bcyc_q     <= 1'b0;
    end else if (adv2) begin
      last_cnt_q <= last_cnt_d;
      have_q     <= have_d;
      idle_q     <= idle_d;
      fcyc_q     <= fcyc_d;
      bcyc_q     <= bcyc_d;
    end
  end

  // ---------------- stages 2..4: result fields ride along the level conversion ----------------
  wfr_kind_e       kind2_q, kind3_q, kind4_q;
  logic [7:0]      cnt2_q, cnt3_q, cnt4_q;
  logic            brk2_q, brk3_q, brk4_q;
  logic            def2_q, def3_q, def4_q;
  logic [OffW-1:0] off2_q;
  logic [9:0]      level;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      kind2_q <= kind2_d;
      cnt2_q  <= cnt2_d;
      brk2_q  <= brk2_d;
      def2_q  <= def2_d;
      off2_q  <= off2_d;
    end
    if (adv3) begin
      kind3_q <= kind2_q;
      cnt3_q  <= cnt2_q;
      brk3_q  <= brk2_q;
      def3_q  <= def2_q;
    end
    if (adv4) begin
      kind4_q <= kind3_q;
      cnt4_q  <= cnt3_q;
      brk4_q  <= brk3_q;
      def4_q  <= def3_q;
    end
  end

  wfr_level u_level (
    .clk_i  (clk_i),
    .adv_i  (lvl_adv),
    .frame_i(kind2_q == KIND_FRAME),
    .off_i  (off2_q),
    .level_o(level)
  );

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {4'd0, def4_q, brk4_q, cnt4_q, level};
  assign m_axis_tuser  = kind4_q;

endmodule

@@ bench/water_frame_receiver_tb.sv @@
// Self-checking testbench of the water frame receiver: stream traffic against a predictor.
module water_frame_receiver_tb;
  import wfr_pkg::*;

  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [31:0] LowUv       = 32'd500000;
  localparam logic [31:0] HighUv      = 32'd2500000;

  typedef struct {
    wfr_kind_e  kind;
    logic [9:0] level_cm;
    logic [7:0] frame_cnt;
    logic       cnt_break;
    logic       defect;
  } level_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic [1:0]  s_axis_tuser  = 2'b00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [7:0]  cfg_data_i    = 8'h00;

  // predictor copy of the block state and registers
  logic [7:0]  rx_window [FrameLen];
  int unsigned rx_fill         = 0;
  logic [7:0]  prev_cnt        = 8'h00;
  logic        have_prev       = 1'b0;
  logic [7:0]  idle_cnt        = 8'h00;
  logic        framed_in_cycle = 1'b0;
  logic        broke_in_cycle  = 1'b0;
  logic [7:0]  timeout_reg     = TimeoutReset;
  logic [7:0]  mk_lo_reg       = MarkerLowReset;
  logic [7:0]  mk_hi_reg       = MarkerHighReset;

  level_report_t report_q [$];

  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned req_cnt      = 0;
  int unsigned rx_hold_left = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;
  logic [7:0]  frame_seq    = 8'h00;

  water_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [9:0] uv_to_level(input logic [31:0] uv);
    longint unsigned delta;
    longint unsigned cm;
    delta = uv - LowUv;
    cm = 50 + (delta * 950) / 2000000;
    if (cm > 1000) cm = 1000;
    return 10'(cm);
  endfunction

  // advance the predicted state by one accepted request and queue its result
  function automatic void predict_report(input wfr_op_e op, input logic [7:0] b,
                                         input logic oper);
    level_report_t r;
    int unsigned   sum;
    logic [7:0]    csum;
    logic [7:0]    nxt;
    logic [31:0]   uv;
    r.kind      = KIND_BYTE;
    r.level_cm  = '0;
    r.frame_cnt = '0;
    r.cnt_break = 1'b0;
    r.defect    = 1'b0;
    if (!oper) begin
      idle_cnt        = 8'h00;
      rx_fill         = 0;
      have_prev       = 1'b0;
      framed_in_cycle = 1'b0;
      broke_in_cycle  = 1'b0;
      if (op == OP_TICK) r.kind = KIND_TICK;
    end else if (op == OP_TICK) begin
      if (!framed_in_cycle && idle_cnt != 8'hFF) idle_cnt = idle_cnt + 8'd1;
      r.kind          = KIND_TICK;
      r.defect        = broke_in_cycle || (idle_cnt >= timeout_reg);
      framed_in_cycle = 1'b0;
      broke_in_cycle  = 1'b0;
    end else begin
      if (rx_fill < FrameLen) begin
        rx_window[rx_fill] = b;
        rx_fill++;
      end else begin
        for (int i = 0; i < FrameLen - 1; i++) rx_window[i] = rx_window[i + 1];
        rx_window[FrameLen - 1] = b;
      end
      if (rx_fill == FrameLen) begin
        sum = 0;
        for (int i = 0; i < 7; i++) sum += rx_window[i];
        csum = 8'(256 - (sum % 256));
        uv   = {rx_window[4], rx_window[3], rx_window[2], rx_window[1]};
        if (rx_window[5] == mk_lo_reg && rx_window[6] == mk_hi_reg &&
            csum == rx_window[7] && uv >= LowUv && uv <= HighUv) begin
          nxt         = prev_cnt + 8'd1;
          r.kind      = KIND_FRAME;
          r.level_cm  = uv_to_level(uv);
          r.frame_cnt = rx_window[0];
          r.cnt_break = have_prev && (rx_window[0] != nxt);
          // a break sticks until the tick that closes the cycle
          if (r.cnt_break) broke_in_cycle = 1'b1;
          prev_cnt        = rx_window[0];
          have_prev       = 1'b1;
          idle_cnt        = 8'h00;
          framed_in_cycle = 1'b1;
        end
      end
    end
    report_q.push_back(r);
  endfunction

  // one request on the input stream; tvalid stays high when no gap follows
  task automatic send_req(input wfr_op_e op, input logic [7:0] b, input logic oper);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {oper, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_report(op, b, oper);
    req_cnt++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // frame with a good checksum under the current markers
  function automatic logic [63:0] build_frame(input logic [7:0] cnt, input logic [31:0] uv);
    logic [63:0] f;
    logic [7:0]  sum;
    f   = {8'h00, mk_hi_reg, mk_lo_reg, uv, cnt};
    sum = 8'h00;
    for (int i = 0; i < 7; i++) sum = sum + f[8*i +: 8];
    f[63:56] = 8'h00 - sum;
    return f;
  endfunction

  task automatic send_frame(input logic [63:0] f);
    for (int i = 0; i < FrameLen; i++) send_req(OP_BYTE, f[8*i +: 8], 1'b1);
  endtask

  function automatic logic [31:0] pick_uv();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return LowUv;
    if (r < 16) return HighUv;
    if (r < 20) return LowUv - 1;
    if (r < 24) return HighUv + 1;
    if (r < 32) return $urandom;
    return $urandom_range(500000, 2500000);
  endfunction

  // sender pauses until every predicted result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input wfr_cfg_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TIMEOUT:     timeout_reg = val;
      CFG_MARKER_LOW:  mk_lo_reg   = val;
      CFG_MARKER_HIGH: mk_hi_reg   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] tmo, input logic [7:0] lo,
                                input logic [7:0] hi);
    wait_drained();
    cfg_write(CFG_TIMEOUT, tmo);
    cfg_write(CFG_MARKER_LOW, lo);
    cfg_write(CFG_MARKER_HIGH, hi);
  endtask

  // mostly well-formed frames with random content, plus noise, corruption and mode drops
  task automatic run_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned r;
    int unsigned k;
    logic [63:0] f;
    start = req_cnt;
    while (req_cnt - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 9) == 0) frame_seq = 8'($urandom);
        f = build_frame(frame_seq, pick_uv());
        frame_seq = frame_seq + 8'd1;
        send_frame(f);
        if ($urandom_range(0, 2) == 0) send_req(OP_TICK, 8'($urandom), 1'b1);
      end else if (r < 65) begin
        f = build_frame(frame_seq, pick_uv());
        k = $urandom_range(0, FrameLen - 1);
        f[8*k +: 8] = f[8*k +: 8] ^ 8'($urandom_range(1, 255));
        send_frame(f);
      end else if (r < 77) begin
        repeat ($urandom_range(1, 6)) send_req(OP_BYTE, 8'($urandom), 1'b1);
      end else if (r < 93) begin
        send_req(OP_TICK, 8'($urandom), 1'b1);
      end else begin
        send_req(wfr_op_e'($urandom_range(0, 1)), 8'($urandom), 1'b0);
      end
    end
  endtask

  // extremes at reset settings: range limits, counter wrap, first frame, break, mode drop
  task automatic test_directed();
    send_frame(build_frame(8'hFF, LowUv));
    send_req(OP_TICK, 8'h00, 1'b1);
    send_frame(build_frame(8'h00, HighUv));
    send_frame(build_frame(8'h07, LowUv + 32'd1000000));
    send_req(OP_TICK, 8'hFF, 1'b1);
    send_req(OP_BYTE, 8'hFF, 1'b0);
    send_req(OP_TICK, 8'h00, 1'b0);
  endtask

  // idle counter saturation at the largest timeout, then timeout zero and one
  task automatic test_idle_timeout();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    apply_settings(8'd255, MarkerLowReset, MarkerHighReset);
    repeat (262) send_req(OP_TICK, 8'($urandom), 1'b1);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    apply_settings(8'd0, MarkerLowReset, MarkerHighReset);
    send_req(OP_TICK, 8'h00, 1'b1);
    send_frame(build_frame(frame_seq, LowUv));
    send_req(OP_TICK, 8'h00, 1'b1);
    apply_settings(8'd1, MarkerLowReset, MarkerHighReset);
    send_frame(build_frame(frame_seq + 8'd1, HighUv));
    repeat (3) send_req(OP_TICK, 8'h00, 1'b1);
  endtask

  task automatic test_config_sweep();
    apply_settings(8'd1, 8'h00, 8'hFF);
    run_traffic(250);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    apply_settings(8'd0, 8'hFF, 8'h00);
    run_traffic(250);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    apply_settings(8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom));
    run_traffic(250);
    apply_settings(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
    run_traffic(250);
    apply_settings(TimeoutReset, MarkerLowReset, MarkerHighReset);
    run_traffic(250);
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    apply_settings(8'd3, 8'h5A, 8'hA5);
    rx_hold_left = 200;
    run_traffic(60);
    wait_drained();
    run_traffic(60);
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    level_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $error("unexpected result: kind %0d data %h", m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        want = report_q.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[9:0] !== want.level_cm) begin
          $error("level_cm: expected %0d, got %0d", want.level_cm, m_axis_tdata[9:0]);
          err_cnt++;
        end
        if (m_axis_tdata[17:10] !== want.frame_cnt) begin
          $error("frame_counter: expected %0d, got %0d", want.frame_cnt, m_axis_tdata[17:10]);
          err_cnt++;
        end
        if (m_axis_tdata[18] !== want.cnt_break) begin
          $error("counter_break: expected %0d, got %0d", want.cnt_break, m_axis_tdata[18]);
          err_cnt++;
        end
        if (m_axis_tdata[19] !== want.defect) begin
          $error("water_defect: expected %0d, got %0d", want.defect, m_axis_tdata[19]);
          err_cnt++;
        end
      end
    end
  end

  initial begin : main
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_timeout();
    test_config_sweep();
    test_backpressure();
    wait_drained();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ water_frame_receiver.f @@
rtl/wfr_pkg.sv
rtl/wfr_cell.sv
rtl/wfr_level.sv
rtl/water_frame_receiver.sv
bench/water_frame_receiver_tb.sv
